/* sv/mandelbrot_escape_time_unit_defines.svh */
// assertion macros for the mandelbrot escape-time unit
// no dependencies; included by the top level only
`ifndef MANDELBROT_ESCAPE_TIME_UNIT_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define MET_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("met assertion failed");
`define MET_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("met assertion failed");
`else
`define MET_ASSERT(lbl, clk, rstn, prop)
`define MET_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* sv/met_pkg.sv */
// shared types and constants of the mandelbrot escape-time unit
// no dependencies
package met_pkg;

  localparam int unsigned COORD_W    = 32;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned HUE_W      = 9;
  localparam int unsigned HUE_SCALE  = 360;
  localparam int unsigned DIVIDEND_W = 25;
  localparam int unsigned DIV_STEPS  = HUE_W;
  localparam int unsigned STEP_W     = $clog2(DIV_STEPS);
  localparam int unsigned ADDR_W     = 5;
  localparam int unsigned DATA_W     = 32;

  localparam logic signed [COORD_W-1:0] X_ORIGIN_RST = 32'shE000_0000;
  localparam logic signed [COORD_W-1:0] X_STEP_RST   = 32'sh000C_0000;
  localparam logic signed [COORD_W-1:0] Y_ORIGIN_RST = 32'shF000_0000;
  localparam logic signed [COORD_W-1:0] Y_STEP_RST   = 32'sh0008_0000;
  localparam logic [CNT_W-1:0]          MAX_ITER_RST = 16'd256;

  typedef enum logic [2:0] {
    REG_X_ORIGIN = 3'd0,
    REG_X_STEP   = 3'd1,
    REG_Y_ORIGIN = 3'd2,
    REG_Y_STEP   = 3'd3,
    REG_MAX_ITER = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_origin;
    logic signed [COORD_W-1:0] x_step;
    logic signed [COORD_W-1:0] y_origin;
    logic signed [COORD_W-1:0] y_step;
    logic [CNT_W-1:0]          max_iter;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAP,
    ST_ITER,
    ST_DIV
  } state_e;

  typedef struct packed {
    logic load_in;
    logic map_sum;
    logic iter_step;
    logic div_start;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic iter_done;
    logic div_busy;
  } status_t;

endpackage

/* sv/met_hue_div.sv */
// restoring divider for the hue, one quotient bit per cycle
// depends on met_pkg
module met_hue_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [met_pkg::DIVIDEND_W-1:0]   dividend_i,
  input  logic [met_pkg::CNT_W-1:0]        divisor_i,
  output logic                             busy_o,
  output logic [met_pkg::HUE_W-1:0]        quotient_o
);

  logic                            busy_q;
  logic [met_pkg::STEP_W-1:0]      step_q;
  logic [met_pkg::DIVIDEND_W-1:0]  rem_q;
  logic [met_pkg::CNT_W-1:0]       divisor_q;
  logic [met_pkg::HUE_W-1:0]       quo_q;
  logic                            zero_q;
  logic [met_pkg::DIVIDEND_W-1:0]  shifted;
  logic                            fits;

  assign shifted = met_pkg::DIVIDEND_W'(divisor_q) << step_q;
  assign fits    = rem_q >= shifted;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && step_q == '0) begin
      busy_q <= 1'b0;
    end
  end

  // quotient is known to stay below 2^HUE_W, so only the low HUE_W quotient bits are tried
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q     <= dividend_i;
      divisor_q <= divisor_i;
      quo_q     <= '0;
      zero_q    <= divisor_i == '0;
      step_q    <= met_pkg::STEP_W'(met_pkg::DIV_STEPS - 1);
    end else if (busy_q) begin
      if (fits) begin
        rem_q         <= rem_q - shifted;
        quo_q[step_q] <= 1'b1;
      end
      step_q <= step_q - 1'b1;
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = zero_q ? '0 : quo_q;

endmodule

/* sv/met_datapath.sv */
// pixel mapping, complex iteration and result registers
// depends on met_pkg and met_hue_div
module met_datapath #(
  parameter int unsigned PIXEL_BITS = 12,
  parameter int unsigned FRAC_BITS  = 28
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  met_pkg::cfg_t               cfg_i,
  input  met_pkg::cmd_t               cmd_i,
  input  logic [PIXEL_BITS-1:0]       pixel_column_i,
  input  logic [PIXEL_BITS-1:0]       pixel_row_i,
  output met_pkg::status_t            status_o,
  output logic [met_pkg::CNT_W-1:0]   iteration_count_o,
  output logic [met_pkg::HUE_W-1:0]   hue_o,
  output logic                        escaped_o
);

  localparam int unsigned CW = met_pkg::COORD_W;
  localparam int unsigned PW = PIXEL_BITS + CW + 1;
  localparam int unsigned ZW = ((FRAC_BITS + 3 > CW) ? FRAC_BITS + 3 : CW) + 1;
  localparam int unsigned SW = FRAC_BITS + 2;
  localparam int unsigned QW = 2 * SW;
  localparam int unsigned AW = ((QW > ZW) ? QW : ZW) + 1;

  localparam logic signed [ZW-1:0] TWO     = ZW'(1) << (FRAC_BITS + 1);
  localparam logic signed [ZW-1:0] NEG_TWO = -TWO;
  localparam logic signed [QW:0]   FOUR    = (QW + 1)'(1) << (2 * FRAC_BITS + 2);

  function automatic logic signed [CW-1:0] sat_coord(input logic signed [PW:0] v);
    logic fits_coord;
    fits_coord = (&v[PW:CW-1]) || ~(|v[PW:CW-1]);
    if (fits_coord) begin
      return v[CW-1:0];
    end else if (v[PW]) begin
      return {1'b1, {(CW - 1){1'b0}}};
    end else begin
      return {1'b0, {(CW - 1){1'b1}}};
    end
  endfunction

  logic signed [PIXEL_BITS:0]  col_s, row_s;
  logic signed [PW-1:0]        xprod_q, yprod_q;
  logic signed [PW:0]          xsum, ysum;
  logic signed [CW-1:0]        cr_q, ci_q;
  logic signed [ZW-1:0]        zr_q, zi_q, zr_d, zi_d;
  logic [met_pkg::CNT_W-1:0]   n_q;
  logic signed [SW-1:0]        xs, ys;
  logic signed [QW-1:0]        rr, ii, ri;
  logic signed [QW:0]          mag;
  logic signed [AW-1:0]        re_w, im_w;
  logic                        in_range, too_big, at_limit;
  logic                        div_busy;
  logic [met_pkg::HUE_W-1:0]   quotient;
  logic [met_pkg::CNT_W-1:0]   count_q;
  logic [met_pkg::HUE_W-1:0]   hue_q;
  logic                        escaped_q;

  // pixel to complex plane
  assign col_s = {1'b0, pixel_column_i};
  assign row_s = {1'b0, pixel_row_i};
  assign xsum  = (PW + 1)'(xprod_q) + (PW + 1)'(cfg_i.x_origin);
  assign ysum  = (PW + 1)'(yprod_q) + (PW + 1)'(cfg_i.y_origin);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      xprod_q <= col_s * cfg_i.x_step;
      yprod_q <= row_s * cfg_i.y_step;
    end
    if (cmd_i.map_sum) begin
      cr_q <= sat_coord(xsum);
      ci_q <= sat_coord(ysum);
    end
  end

  // one z = z*z + c step per cycle; squares are only used while both parts are below 2
  assign xs  = zr_q[SW-1:0];
  assign ys  = zi_q[SW-1:0];
  assign rr  = xs * xs;
  assign ii  = ys * ys;
  assign ri  = xs * ys;
  assign mag = (QW + 1)'(rr) + (QW + 1)'(ii);

  assign in_range = (zr_q < TWO) && (zr_q > NEG_TWO) && (zi_q < TWO) && (zi_q > NEG_TWO);
  assign too_big  = mag >= FOUR;
  assign at_limit = n_q >= cfg_i.max_iter;

  assign re_w = AW'(rr) - AW'(ii);
  assign im_w = AW'(ri) <<< 1;
  assign zr_d = ZW'((re_w >>> FRAC_BITS) + AW'(cr_q));
  assign zi_d = ZW'((im_w >>> FRAC_BITS) + AW'(ci_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.map_sum) begin
      zr_q <= '0;
      zi_q <= '0;
      n_q  <= '0;
    end else if (cmd_i.iter_step) begin
      zr_q <= zr_d;
      zi_q <= zi_d;
      n_q  <= n_q + 1'b1;
    end
  end

  assign status_o.iter_done = at_limit || !in_range || too_big;
  assign status_o.div_busy  = div_busy;

  met_hue_div u_hue_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (met_pkg::DIVIDEND_W'(n_q) * met_pkg::DIVIDEND_W'(met_pkg::HUE_SCALE)),
    .divisor_i  (cfg_i.max_iter),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      count_q   <= n_q;
      hue_q     <= quotient;
      escaped_q <= !at_limit;
    end
  end

  assign iteration_count_o = count_q;
  assign hue_o             = hue_q;
  assign escaped_o         = escaped_q;

endmodule

/* sv/met_ctrl.sv */
// sequencer for one pixel at a time plus the output valid flag
// depends on met_pkg
module met_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              out_ready_i,
  input  met_pkg::status_t  status_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output met_pkg::cmd_t     cmd_o
);

  met_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      met_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = met_pkg::ST_MAP;
      end
      met_pkg::ST_MAP: begin
        state_d = met_pkg::ST_ITER;
      end
      met_pkg::ST_ITER: begin
        if (status_i.iter_done) state_d = met_pkg::ST_DIV;
      end
      met_pkg::ST_DIV: begin
        if (!status_i.div_busy && out_free) state_d = met_pkg::ST_IDLE;
      end
      default: begin
        state_d = met_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      met_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      met_pkg::ST_MAP: begin
        cmd_o.map_sum = 1'b1;
      end
      met_pkg::ST_ITER: begin
        cmd_o.iter_step = !status_i.iter_done;
        cmd_o.div_start = status_i.iter_done;
      end
      met_pkg::ST_DIV: begin
        // result register may be refilled in the cycle it is taken
        cmd_o.out_load = !status_i.div_busy && out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  assign out_valid_d = cmd_o.out_load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= met_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* sv/mandelbrot_escape_time_unit.sv */
// Mandelbrot escape-time unit: one pixel in, iteration count, hue and escape flag out.
// Input channel (in_valid_i/in_ready_o) takes a pixel column and row; output channel
// (out_valid_o/out_ready_i) returns one result item per pixel. The APB port holds the
// plane origin and steps (signed Q4.28) and the iteration limit; write it only while idle.
// Per item the block does the origin add and saturation (the step products are taken at
// the accepting edge), then the iteration loop (at most max_iterations steps), then the
// hue divider and last the load of the result register, which raises out_valid_o.
// The rate is set by the single complex square-and-add unit, which runs one iteration per
// cycle, and the bit-serial hue divider. One item is worked on at a time.
// A finished result sits in the output register; the next pixel is accepted meanwhile, and
// if the receiver still stalls when that pixel is done, the block waits after the divider.
// Reset clears the sequencer and the output valid flag and loads the default view
// (origin -2.0 - 1.0i, limit 256).
// depends on met_pkg, met_ctrl, met_datapath and the assertion macro header
`include "mandelbrot_escape_time_unit_defines.svh"

module mandelbrot_escape_time_unit #(
  parameter int unsigned PIXEL_BITS = 12,
  parameter int unsigned FRAC_BITS  = 28
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [met_pkg::ADDR_W-1:0]    paddr,
  input  logic [met_pkg::DATA_W-1:0]    pwdata,
  output logic [met_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [PIXEL_BITS-1:0]         pixel_column_i,
  input  logic [PIXEL_BITS-1:0]         pixel_row_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [met_pkg::CNT_W-1:0]     iteration_count_o,
  output logic [met_pkg::HUE_W-1:0]     hue_o,
  output logic                          escaped_o
);

  met_pkg::cfg_t     cfg_q;
  met_pkg::reg_idx_e reg_idx;
  met_pkg::cmd_t     cmd;
  met_pkg::status_t  status;
  logic              cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = met_pkg::reg_idx_e'(paddr[met_pkg::ADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_origin <= met_pkg::X_ORIGIN_RST;
      cfg_q.x_step   <= met_pkg::X_STEP_RST;
      cfg_q.y_origin <= met_pkg::Y_ORIGIN_RST;
      cfg_q.y_step   <= met_pkg::Y_STEP_RST;
      cfg_q.max_iter <= met_pkg::MAX_ITER_RST;
    end else if (cfg_write) begin
      unique case (reg_idx)
        met_pkg::REG_X_ORIGIN: cfg_q.x_origin <= pwdata;
        met_pkg::REG_X_STEP:   cfg_q.x_step   <= pwdata;
        met_pkg::REG_Y_ORIGIN: cfg_q.y_origin <= pwdata;
        met_pkg::REG_Y_STEP:   cfg_q.y_step   <= pwdata;
        met_pkg::REG_MAX_ITER: cfg_q.max_iter <= pwdata[met_pkg::CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      met_pkg::REG_X_ORIGIN: prdata = cfg_q.x_origin;
      met_pkg::REG_X_STEP:   prdata = cfg_q.x_step;
      met_pkg::REG_Y_ORIGIN: prdata = cfg_q.y_origin;
      met_pkg::REG_Y_STEP:   prdata = cfg_q.y_step;
      met_pkg::REG_MAX_ITER: prdata = met_pkg::DATA_W'(cfg_q.max_iter);
      default:               prdata = '0;
    endcase
  end

  met_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  met_datapath #(
    .PIXEL_BITS (PIXEL_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .cmd_i             (cmd),
    .pixel_column_i    (pixel_column_i),
    .pixel_row_i       (pixel_row_i),
    .status_o          (status),
    .iteration_count_o (iteration_count_o),
    .hue_o             (hue_o),
    .escaped_o         (escaped_o)
  );

  `MET_ASSERT_ALWAYS(a_hue_bound, clk_i, out_valid_o |-> hue_o <= met_pkg::HUE_W'(met_pkg::HUE_SCALE))
  `MET_ASSERT(a_escaped_below_limit, clk_i, rst_ni, out_valid_o && escaped_o |-> iteration_count_o < cfg_q.max_iter)
  `MET_ASSERT(a_inside_at_limit, clk_i, rst_ni, out_valid_o && !escaped_o |-> iteration_count_o == cfg_q.max_iter)
  `MET_ASSERT(a_one_item_at_a_time, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o)

endmodule
